@@ src/nlms_adaptive_fir_unit_macros.svh @@
// Assertion macros used by the NLMS adaptive FIR core.
`ifndef NLMS_ADAPTIVE_FIR_UNIT_MACROS_SVH
`define NLMS_ADAPTIVE_FIR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define NAFU_ASSERT(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("nafu: check failed");
`define NAFU_ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk_i) prop) \
  else $error("nafu: check failed");
`else
`define NAFU_ASSERT(lbl, prop)
`define NAFU_ASSERT_RST(lbl, prop)
`endif
`endif

@@ src/nafu_pkg.sv @@
// Shared types and constants of the NLMS adaptive FIR.
package nafu_pkg;

  localparam int unsigned STEP_W     = 16;
  localparam int unsigned REG_W      = 20;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [STEP_W-1:0] STEP_RST = 16'd32768;
  localparam logic [REG_W-1:0]  REG_RST  = 20'd10737;
  localparam logic [DZ_W-1:0]   DZ_RST   = 15'd3;

  localparam int unsigned W_W      = 32;  // Q4.28 weight
  localparam int unsigned W_FRAC   = 28;
  localparam int unsigned EN_W     = 36;  // Q6.30 energy
  localparam int unsigned DEN_W    = 37;
  localparam int unsigned NUM_W    = 62;  // step * |err * tap| at Q.44 scale
  localparam int unsigned DIVD_W   = 63;
  localparam int unsigned Q_W      = 33;
  localparam int unsigned QLIM_SH  = 32;

  localparam logic [EN_W-1:0] ENERGY_MAX = 36'hF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP  = 2'd0,
    CFG_REGUL = 2'd1,
    CFG_DZONE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [STEP_W-1:0] step_size;
    logic [REG_W-1:0]  regularizer;
    logic [DZ_W-1:0]   dead_zone;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILT,
    ST_FIN1,
    ST_FIN2,
    ST_UADDR,
    ST_UMUL1,
    ST_UMUL2,
    ST_UDIVS,
    ST_UDIV,
    ST_UWB
  } core_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_CHECK,
    DIV_RUN
  } div_state_e;

endpackage

@@ src/nafu_front.sv @@
// Front end: config registers and a two-entry sample queue.
module nafu_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned IO_W        = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [IO_W-1:0]                  s_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nafu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nafu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             hold_i,
  output nafu_pkg::cfg_t                   cfg_o,
  output logic                             q_valid_o,
  output logic [3*SAMPLE_BITS-1:0]         q_data_o,
  input  logic                             q_pop_i
);

  localparam int unsigned QD_W = 3 * SAMPLE_BITS;

  nafu_pkg::cfg_t cfg_q, cfg_d;
  logic [QD_W-1:0] fifo_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_q, rd_q;
  logic push, pop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !hold_i && (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_data_o      = fifo_q[rd_q];
  assign cfg_o         = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        nafu_pkg::CFG_STEP:  cfg_d.step_size   = cfg_data_i[nafu_pkg::STEP_W-1:0];
        nafu_pkg::CFG_REGUL: cfg_d.regularizer = cfg_data_i[nafu_pkg::REG_W-1:0];
        nafu_pkg::CFG_DZONE: cfg_d.dead_zone   = cfg_data_i[nafu_pkg::DZ_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size   <= nafu_pkg::STEP_RST;
      cfg_q.regularizer <= nafu_pkg::REG_RST;
      cfg_q.dead_zone   <= nafu_pkg::DZ_RST;
      cnt_q             <= 2'd0;
      wr_q              <= 1'b0;
      rd_q              <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      cnt_q <= cnt_d;
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= s_axis_tdata[QD_W-1:0];
  end

endmodule

@@ src/nafu_div.sv @@
// Rounded, clamped weight-step divider, one quotient bit per cycle.
module nafu_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [nafu_pkg::NUM_W-1:0]   num_i,
  input  logic [nafu_pkg::DEN_W-1:0]   den_i,
  output logic                         done_o,
  output logic [nafu_pkg::Q_W-1:0]     quot_o
);

  localparam int unsigned DV = nafu_pkg::DIVD_W;
  localparam int unsigned DN = nafu_pkg::DEN_W;
  localparam int unsigned QW = nafu_pkg::Q_W;
  localparam int unsigned LIM_W = DN + nafu_pkg::QLIM_SH + 1;

  nafu_pkg::div_state_e st_q;
  logic [DV-1:0] n_q;
  logic [DN-1:0] d_q, rem_q;
  logic [QW-1:0] sh_q, quot_q;
  logic [5:0] cnt_q;
  logic done_q;
  logic [LIM_W-1:0] lim;
  logic [DN:0] r2, r2_sub;
  logic ge;

  // quotient exceeds 2^32 when n >= d * (2^32 + 1)
  assign lim    = (LIM_W'(d_q) << nafu_pkg::QLIM_SH) + LIM_W'(d_q);
  assign r2     = {rem_q, sh_q[QW-1]};
  assign ge     = r2 >= {1'b0, d_q};
  assign r2_sub = r2 - {1'b0, d_q};
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= nafu_pkg::DIV_IDLE;
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        nafu_pkg::DIV_IDLE: begin
          if (start_i) st_q <= nafu_pkg::DIV_CHECK;
        end
        nafu_pkg::DIV_CHECK: begin
          if (LIM_W'(n_q) >= lim) begin
            st_q   <= nafu_pkg::DIV_IDLE;
            done_q <= 1'b1;
          end else begin
            st_q  <= nafu_pkg::DIV_RUN;
            cnt_q <= 6'(QW);
          end
        end
        nafu_pkg::DIV_RUN: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            st_q   <= nafu_pkg::DIV_IDLE;
            done_q <= 1'b1;
          end
        end
        default: st_q <= nafu_pkg::DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == nafu_pkg::DIV_IDLE && start_i) begin
      n_q <= DV'(num_i) + DV'(den_i >> 1);
      d_q <= den_i;
    end
    if (st_q == nafu_pkg::DIV_CHECK) begin
      rem_q  <= DN'(n_q[DV-1:QW]);
      sh_q   <= n_q[QW-1:0];
      quot_q <= QW'(1) << nafu_pkg::QLIM_SH;
    end
    if (st_q == nafu_pkg::DIV_RUN) begin
      rem_q  <= ge ? r2_sub[DN-1:0] : r2[DN-1:0];
      sh_q   <= sh_q << 1;
      quot_q <= {quot_q[QW-2:0], ge};
    end
  end

endmodule

@@ src/nafu_core.sv @@
// Back end: post-reset clear, filter pass, error/clean outputs and NLMS weight update.
`include "nlms_adaptive_fir_unit_macros.svh"
module nafu_core #(
  parameter int unsigned TAPS        = 30,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned IO_W        = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nafu_pkg::cfg_t             cfg_i,
  input  logic                       q_valid_i,
  input  logic [3*SAMPLE_BITS-1:0]   q_data_i,
  output logic                       q_pop_o,
  output logic                       clearing_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [IO_W-1:0]            out_data_o
);

  localparam int unsigned S      = SAMPLE_BITS;
  localparam int unsigned F      = S - 1;
  localparam int unsigned IDX_W  = $clog2(TAPS);
  localparam int unsigned CNT_W  = $clog2(TAPS + 1);
  localparam int unsigned WW     = nafu_pkg::W_W;
  localparam int unsigned PROD_W = WW + S;
  localparam int unsigned ACC_W  = PROD_W + IDX_W;
  localparam int unsigned Y_W    = ACC_W - nafu_pkg::W_FRAC;
  localparam int unsigned SQ_W   = 2 * S;
  localparam int unsigned ESUM_W = SQ_W + IDX_W;
  localparam int unsigned SHR    = (2 * F >= 30) ? (2 * F - 30) : 0;
  localparam int unsigned SHL    = (2 * F >= 30) ? 0 : (30 - 2 * F);
  localparam int unsigned ENX_W  = ESUM_W + SHL;
  localparam int unsigned ECMP_W = ((ENX_W > nafu_pkg::EN_W) ? ENX_W : nafu_pkg::EN_W) + 1;
  localparam int unsigned NSHL   = (2 * F <= 44) ? (44 - 2 * F) : 0;
  localparam int unsigned NSHR   = (2 * F > 44) ? (2 * F - 44) : 0;
  localparam int unsigned NUM0_W = 2 * S + nafu_pkg::STEP_W;
  localparam int unsigned NUMX_W = NUM0_W + NSHL;
  localparam int unsigned MW     = (S > nafu_pkg::DZ_W) ? S : nafu_pkg::DZ_W;
  localparam int unsigned DN     = nafu_pkg::DEN_W;

  typedef logic signed [S-1:0] smp_t;

  function automatic smp_t sat_smp(input logic signed [Y_W:0] v);
    logic signed [Y_W:0] hi, lo;
    hi = (Y_W+1)'((1 << F) - 1);
    lo = -(Y_W+1)'(1 << F);
    if (v > hi) sat_smp = smp_t'(hi);
    else if (v < lo) sat_smp = smp_t'(lo);
    else sat_smp = smp_t'(v);
  endfunction

  nafu_pkg::core_state_e st_q, st_d;

  // memories
  smp_t tap_mem [TAPS];
  logic signed [WW-1:0] wt_mem [TAPS];
  smp_t tap_rd_q;
  logic signed [WW-1:0] wt_rd_q;
  logic tap_we, wt_we, rd_en;
  logic [IDX_W-1:0] tap_waddr, wt_waddr, wt_raddr;
  smp_t tap_wdata;
  logic signed [WW-1:0] wt_wdata;

  // control
  logic [IDX_W-1:0] wp_q, cur_wp_q, ridx_q, clr_q, ridx_nx;
  logic [CNT_W-1:0] k_q;
  logic rd_v_q, mul_v_q, out_valid_q;
  logic issue, out_free, out_load, upd_go, last_tap, div_start, div_done;

  // datapath
  smp_t des_q, pri_q, err_q, yo, err_c, clean_c;
  logic signed [PROD_W-1:0] prod_q;
  logic [SQ_W-1:0] sq_q;
  logic signed [SQ_W-1:0] sq_s;
  logic signed [ACC_W-1:0] acc_q;
  logic [ESUM_W-1:0] esum_q;
  logic signed [Y_W-1:0] y_q;
  logic [nafu_pkg::EN_W-1:0] en_q;
  logic [DN-1:0] denom_c, denom_q;
  logic signed [SQ_W-1:0] u_prod_q;
  logic [SQ_W-1:0] u_mag;
  logic [NUM0_W-1:0] num0;
  logic [NUMX_W-1:0] numx;
  logic [nafu_pkg::NUM_W-1:0] num_q;
  logic signed [WW-1:0] u_w_q;
  logic [nafu_pkg::Q_W-1:0] quot;
  logic signed [WW+2:0] w_new;
  logic signed [WW-1:0] w_sat;
  logic [MW-1:0] err_mag;
  logic [IO_W-1:0] out_data_q;
  logic signed [ACC_W-1:0] acc_rnd;
  logic [ENX_W-1:0] enx;
  logic [ECMP_W-1:0] ecmp;

  assign ridx_nx    = (ridx_q == '0) ? IDX_W'(TAPS - 1) : ridx_q - 1'b1;
  assign issue      = (st_q == nafu_pkg::ST_FILT) && (k_q < CNT_W'(TAPS));
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_tap   = (k_q == CNT_W'(TAPS - 1));
  assign clearing_o = (st_q == nafu_pkg::ST_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign wt_raddr   = k_q[IDX_W-1:0];

  // finish: output fields, dead zone and denominator
  always_comb begin
    yo      = sat_smp((Y_W+1)'(y_q));
    err_c   = sat_smp((Y_W+1)'(des_q) - (Y_W+1)'(y_q));
    clean_c = sat_smp((Y_W+1)'(pri_q) - (Y_W+1)'(y_q));
    err_mag = err_c[S-1] ? MW'(-(S+1)'(err_c)) : MW'(err_c);
    if (err_mag < MW'(cfg_i.dead_zone)) err_c = '0;
    denom_c = DN'(en_q) + DN'(cfg_i.regularizer);
    upd_go  = (denom_c != '0) && (err_c != '0) && (cfg_i.step_size != '0);
  end

  assign acc_rnd = acc_q + ACC_W'(1 << (nafu_pkg::W_FRAC - 1));
  assign enx     = (ENX_W'(esum_q) << SHL) >> SHR;
  assign ecmp    = ECMP_W'(enx);
  assign sq_s    = tap_rd_q * tap_rd_q;
  assign u_mag   = u_prod_q[SQ_W-1] ? SQ_W'(-u_prod_q) : SQ_W'(u_prod_q);
  assign num0    = NUM0_W'(u_mag) * NUM0_W'(cfg_i.step_size);
  assign numx    = (NUMX_W'(num0) << NSHL) >> NSHR;
  assign w_new   = u_prod_q[SQ_W-1] ? ((WW+3)'(u_w_q) - (WW+3)'(quot))
                                    : ((WW+3)'(u_w_q) + (WW+3)'(quot));
  always_comb begin
    if (w_new > (WW+3)'(32'sh7FFF_FFFF)) w_sat = 32'sh7FFF_FFFF;
    else if (w_new < -(WW+3)'(64'sh8000_0000)) w_sat = 32'sh8000_0000;
    else w_sat = w_new[WW-1:0];
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      nafu_pkg::ST_CLEAR: if (clr_q == IDX_W'(TAPS - 1)) st_d = nafu_pkg::ST_IDLE;
      nafu_pkg::ST_IDLE:  if (q_valid_i) st_d = nafu_pkg::ST_FILT;
      nafu_pkg::ST_FILT:  if (!issue && !rd_v_q && !mul_v_q) st_d = nafu_pkg::ST_FIN1;
      nafu_pkg::ST_FIN1:  st_d = nafu_pkg::ST_FIN2;
      nafu_pkg::ST_FIN2: begin
        if (out_free) st_d = upd_go ? nafu_pkg::ST_UADDR : nafu_pkg::ST_IDLE;
      end
      nafu_pkg::ST_UADDR: st_d = nafu_pkg::ST_UMUL1;
      nafu_pkg::ST_UMUL1: st_d = nafu_pkg::ST_UMUL2;
      nafu_pkg::ST_UMUL2: begin
        // a zero product leaves the weight unchanged
        if (u_prod_q != '0) st_d = nafu_pkg::ST_UDIVS;
        else st_d = last_tap ? nafu_pkg::ST_IDLE : nafu_pkg::ST_UADDR;
      end
      nafu_pkg::ST_UDIVS: st_d = nafu_pkg::ST_UDIV;
      nafu_pkg::ST_UDIV:  if (div_done) st_d = nafu_pkg::ST_UWB;
      nafu_pkg::ST_UWB:   st_d = last_tap ? nafu_pkg::ST_IDLE : nafu_pkg::ST_UADDR;
      default:            st_d = nafu_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    tap_we    = 1'b0;
    tap_waddr = wp_q;
    tap_wdata = smp_t'(q_data_i[S-1:0]);
    wt_we     = 1'b0;
    wt_waddr  = k_q[IDX_W-1:0];
    wt_wdata  = w_sat;
    rd_en     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (st_q)
      nafu_pkg::ST_CLEAR: begin
        tap_we    = 1'b1;
        tap_waddr = clr_q;
        tap_wdata = '0;
        wt_we     = 1'b1;
        wt_waddr  = clr_q;
        wt_wdata  = '0;
      end
      nafu_pkg::ST_IDLE: begin
        q_pop_o = q_valid_i;
        tap_we  = q_valid_i;
      end
      nafu_pkg::ST_FILT:  rd_en = issue;
      nafu_pkg::ST_FIN2:  out_load = out_free;
      nafu_pkg::ST_UADDR: rd_en = 1'b1;
      nafu_pkg::ST_UDIVS: div_start = 1'b1;
      nafu_pkg::ST_UWB:   wt_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) tap_mem[tap_waddr] <= tap_wdata;
    if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
    if (rd_en) begin
      tap_rd_q <= tap_mem[ridx_q];
      wt_rd_q  <= wt_mem[wt_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= nafu_pkg::ST_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      cur_wp_q    <= '0;
      ridx_q      <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
      if (st_q == nafu_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (q_pop_o) begin
        cur_wp_q <= wp_q;
        ridx_q   <= wp_q;
        k_q      <= '0;
        wp_q     <= (wp_q == IDX_W'(TAPS - 1)) ? '0 : wp_q + 1'b1;
      end
      if (issue) begin
        k_q    <= k_q + 1'b1;
        ridx_q <= ridx_nx;
      end
      if (st_q == nafu_pkg::ST_FIN2) begin
        k_q    <= '0;
        ridx_q <= cur_wp_q;
      end
      if ((st_q == nafu_pkg::ST_UWB) ||
          (st_q == nafu_pkg::ST_UMUL2 && u_prod_q == '0)) begin
        k_q    <= k_q + 1'b1;
        ridx_q <= ridx_nx;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= wt_rd_q * tap_rd_q;
    sq_q     <= sq_s;
    u_prod_q <= err_q * tap_rd_q;
    num_q    <= numx[nafu_pkg::NUM_W-1:0];
    if (q_pop_o) begin
      des_q  <= smp_t'(q_data_i[2*S-1:S]);
      pri_q  <= smp_t'(q_data_i[3*S-1:2*S]);
      acc_q  <= '0;
      esum_q <= '0;
    end
    if (mul_v_q) begin
      acc_q  <= acc_q + ACC_W'(prod_q);
      esum_q <= esum_q + ESUM_W'(sq_q);
    end
    if (st_q == nafu_pkg::ST_FIN1) begin
      y_q  <= Y_W'(acc_rnd >>> nafu_pkg::W_FRAC);
      en_q <= (ecmp > ECMP_W'(nafu_pkg::ENERGY_MAX)) ? nafu_pkg::ENERGY_MAX
                                                     : ecmp[nafu_pkg::EN_W-1:0];
    end
    if (st_q == nafu_pkg::ST_FIN2) begin
      err_q   <= err_c;
      denom_q <= denom_c;
    end
    if (st_q == nafu_pkg::ST_UMUL1) u_w_q <= wt_rd_q;
    if (out_load) out_data_q <= IO_W'({clean_c, err_c, yo});
  end

  nafu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (denom_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  `NAFU_ASSERT(a_pop_starts_filter, q_pop_o |=> (st_q == nafu_pkg::ST_FILT))
  `NAFU_ASSERT(a_load_needs_slot, out_load |-> (!out_valid_q || out_ready_i))
  `NAFU_ASSERT(a_wp_in_range, wp_q <= IDX_W'(TAPS - 1))
  `NAFU_ASSERT(a_div_done_in_wait, div_done |-> (st_q == nafu_pkg::ST_UDIV))

endmodule

@@ src/nlms_adaptive_fir_unit.sv @@
// NLMS adaptive FIR: one result per sample triple. After reset the tap line and weights are
// cleared, and no sample is taken meanwhile. Each item then runs a filter pass (one tap per
// cycle), and when it adapts, an update pass that uses the one-bit-per-cycle divider
// (33 steps) to form each weight step; taps whose error-times-sample product is zero skip
// the divider. A two-entry queue takes new samples while an item is at work, and the result
// sits in an output register.
module nlms_adaptive_fir_unit #(
  parameter int unsigned TAPS        = 30,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // reference_sample, desired_sample, primary_sample (low bits first), zero padded
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // filter_output, error_value, cleaned_output (low bits first), zero padded
  output logic [((3*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nafu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [nafu_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IO_W = ((3 * SAMPLE_BITS + 7) / 8) * 8;

  nafu_pkg::cfg_t cfg;
  logic q_valid, q_pop, clearing;
  logic [3*SAMPLE_BITS-1:0] q_data;

  nafu_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .IO_W        (IO_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .hold_i        (clearing),
    .cfg_o         (cfg),
    .q_valid_o     (q_valid),
    .q_data_o      (q_data),
    .q_pop_i       (q_pop)
  );

  nafu_core #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IO_W        (IO_W)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
